// ===== rtl/texture_nearest_sampler_core_assert.svh =====
// Assertion macros shared by the sampler RTL.
`ifndef TEXTURE_NEAREST_SAMPLER_CORE_ASSERT_SVH
`define TEXTURE_NEAREST_SAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TNS_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sampler assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TNS_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sampler assertion failed");

`endif

// ===== rtl/tns_pkg.sv =====
// Types and constants of the nearest-neighbor texture sampler.
`default_nettype none
package tns_pkg;

  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 65536;
  localparam int REG_W       = 9;
  localparam int TEXEL_W     = 32;
  localparam int COORD_W     = 32;
  localparam int CHAN_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int QDEPTH      = 8;

  // alpha 255, blue 255, green 0, red 255
  localparam logic [TEXEL_W-1:0] MAGENTA = 32'hFFFF_00FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  // One texel-store access leaving the address pipeline.
  typedef struct packed {
    logic                valid;
    logic                write;
    logic                magenta;
    logic [ADDR_W-1:0]   addr;
    logic [TEXEL_W-1:0]  data;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== rtl/tns_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module tns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tns_addr.sv =====
// Coordinate wrap, scale and row-major index pipeline (three stages).
`default_nettype none
module tns_addr #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 9
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_fire,
  input  wire logic                           is_sample,
  input  wire logic [tns_pkg::ADDR_W-1:0]     texel_addr,
  input  wire logic [tns_pkg::TEXEL_W-1:0]    texel_rgba,
  input  wire logic [tns_pkg::COORD_W-1:0]    u_coord,
  input  wire logic [tns_pkg::COORD_W-1:0]    v_coord,
  input  wire logic [SIDE_W-1:0]              w_side,
  input  wire logic [SIDE_W-1:0]              h_side,
  input  wire logic                           no_tex,
  output tns_pkg::mem_req_t                   req
);

  localparam int PW_U = FRAC_BITS + SIDE_W;
  localparam int PW_V = FRAC_BITS + 1 + SIDE_W;
  localparam int IW   = 2 * SIDE_W + 1;

  localparam logic [FRAC_BITS:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // stage 1: wrapped fractions
  logic                          s1_valid;
  logic                          s1_write;
  logic                          s1_magenta;
  logic [tns_pkg::ADDR_W-1:0]    s1_addr;
  logic [tns_pkg::TEXEL_W-1:0]   s1_data;
  logic [FRAC_BITS-1:0]          s1_uf;
  logic [FRAC_BITS:0]            s1_vf;

  // stage 2: texel column and row
  logic                          s2_valid;
  logic                          s2_write;
  logic                          s2_magenta;
  logic [tns_pkg::ADDR_W-1:0]    s2_addr;
  logic [tns_pkg::TEXEL_W-1:0]   s2_data;
  logic [SIDE_W-1:0]             s2_x;
  logic [SIDE_W-1:0]             s2_y;

  logic [SIDE_W-1:0]             w_m1;
  logic [SIDE_W-1:0]             h_m1;
  logic [PW_U-1:0]               prod_u;
  logic [PW_V-1:0]               prod_v;
  logic [IW-1:0]                 idx_full;

  always_comb begin
    w_m1     = w_side - SIDE_W'(1);
    h_m1     = h_side - SIDE_W'(1);
    prod_u   = PW_U'(s1_uf) * PW_U'(w_m1);
    prod_v   = PW_V'(s1_vf) * PW_V'(h_m1);
    idx_full = IW'(s2_y) * IW'(w_side) + IW'(s2_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      req.valid <= 1'b0;
    end else begin
      s1_valid  <= in_fire;
      s2_valid  <= s1_valid;
      req.valid <= s2_valid;
    end
    // stage 1
    s1_write   <= !is_sample;
    s1_magenta <= is_sample && no_tex;
    s1_addr    <= texel_addr;
    s1_data    <= texel_rgba;
    s1_uf      <= u_coord[FRAC_BITS-1:0];
    s1_vf      <= FX_ONE - {1'b0, v_coord[FRAC_BITS-1:0]};
    // stage 2: fractions of at most one keep products within side-1, no clamp needed
    s2_write   <= s1_write;
    s2_magenta <= s1_magenta;
    s2_addr    <= s1_addr;
    s2_data    <= s1_data;
    s2_x       <= prod_u[PW_U-1:FRAC_BITS];
    s2_y       <= prod_v[FRAC_BITS+SIDE_W-1:FRAC_BITS];
    // stage 3
    req.write   <= s2_write;
    req.magenta <= s2_magenta;
    req.addr    <= s2_write ? s2_addr : tns_pkg::ADDR_W'(idx_full);
    req.data    <= s2_data;
  end

endmodule
`default_nettype wire

// ===== rtl/tns_outq.sv =====
// Result queue in front of the output channel.
`default_nettype none
`include "texture_nearest_sampler_core_assert.svh"
module tns_outq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [tns_pkg::TEXEL_W-1:0]  push_data,
  input  wire logic                         pop,
  output logic                              not_empty,
  output logic      [tns_pkg::TEXEL_W-1:0]  head
);

  localparam int PW = $clog2(tns_pkg::QDEPTH);
  localparam int CW = $clog2(tns_pkg::QDEPTH + 1);

  logic [tns_pkg::TEXEL_W-1:0] slot [tns_pkg::QDEPTH];
  logic [PW-1:0]               wr_ptr;
  logic [PW-1:0]               rd_ptr;
  logic [CW-1:0]               count;

  assign not_empty = (count != '0);
  assign head      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  `TNS_ASSERT_NOW(a_no_overflow, push && !pop, count < CW'(tns_pkg::QDEPTH))
  `TNS_ASSERT_NOW(a_no_underflow, pop, count != '0)
  `TNS_ASSERT_NEXT(a_push_shows, push, count != '0)

endmodule
`default_nettype wire

// ===== rtl/texture_nearest_sampler_core.sv =====
// Top level of the nearest-neighbor, repeat-wrap texture sampler.
`default_nettype none
`include "texture_nearest_sampler_core_assert.svh"
// Nearest-neighbor texture sampler over a 64K x 32 RGBA8 texel store.
// Load transfers (kind 0) write texel_rgba at texel_addr; sample transfers
// (kind 1) wrap u and v (signed, FRAC_BITS fraction bits) to their fraction,
// flip v, scale by side-1, and return the four bytes of texel y*width+x
// (index taken mod 65536). A zero width or height returns magenta. Sides above
// MAX_SIDE saturate. One transfer per cycle is taken while fewer than eight
// samples are pending. A sample result passes through the address pipeline
// (wrap, scale multiply, index multiply-add), the texel store read stage and
// the result queue. Loads and reads share the single store port in transfer
// order, so a sample sees every earlier load. The eight-entry result queue
// and an in-flight counter keep input ready high while fewer than eight
// samples are pending, so the output may stall without backing up input
// until eight samples are pending. tex_width/tex_height are written
// through cfg_we/cfg_index/cfg_data and must only change while the block is
// idle. Texels never written read back as unspecified data.
module texture_nearest_sampler_core #(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [tns_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tns_pkg::REG_W-1:0]         cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              kind,
  input  wire logic [tns_pkg::ADDR_W-1:0]        texel_addr,
  input  wire logic [tns_pkg::TEXEL_W-1:0]       texel_rgba,
  input  wire logic signed [tns_pkg::COORD_W-1:0] u_coord,
  input  wire logic signed [tns_pkg::COORD_W-1:0] v_coord,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [tns_pkg::CHAN_W-1:0]        red,
  output logic      [tns_pkg::CHAN_W-1:0]        green,
  output logic      [tns_pkg::CHAN_W-1:0]        blue,
  output logic      [tns_pkg::CHAN_W-1:0]        alpha
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int PEND_W = $clog2(tns_pkg::QDEPTH + 1);

  // configuration registers
  logic [tns_pkg::REG_W-1:0] tex_width;
  logic [tns_pkg::REG_W-1:0] tex_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= '0;
      tex_height <= '0;
    end else if (cfg_we) begin
      unique case (tns_pkg::cfg_reg_t'(cfg_index))
        tns_pkg::REG_TEX_WIDTH:  tex_width  <= cfg_data;
        tns_pkg::REG_TEX_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturated sides; the user must keep config static while items are in flight, the block does not enforce it
  logic [31:0]       w_int;
  logic [31:0]       h_int;
  logic [SIDE_W-1:0] w_side;
  logic [SIDE_W-1:0] h_side;
  logic              no_tex;

  always_comb begin
    w_int  = (32'(tex_width)  > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : 32'(tex_width);
    h_int  = (32'(tex_height) > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : 32'(tex_height);
    w_side = w_int[SIDE_W-1:0];
    h_side = h_int[SIDE_W-1:0];
    no_tex = (tex_width == '0) || (tex_height == '0);
  end

  // input transfer and sample credit tracking
  logic              in_fire;
  logic              is_sample;
  logic              out_fire;
  logic [PEND_W-1:0] pending;

  assign is_sample = (kind == tns_pkg::KIND_SAMPLE);
  assign in_ready  = (pending < PEND_W'(tns_pkg::QDEPTH));
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if ((in_fire && is_sample) && !out_fire) begin
      pending <= pending + PEND_W'(1);
    end else if (!(in_fire && is_sample) && out_fire) begin
      pending <= pending - PEND_W'(1);
    end
  end

  // address pipeline
  tns_pkg::mem_req_t req;

  tns_addr #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SIDE_W)
  ) u_addr (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .is_sample  (is_sample),
    .texel_addr (texel_addr),
    .texel_rgba (texel_rgba),
    .u_coord    (u_coord),
    .v_coord    (v_coord),
    .w_side     (w_side),
    .h_side     (h_side),
    .no_tex     (no_tex),
    .req        (req)
  );

  // texel store: at most one access per item, in transfer order; magenta samples skip it
  logic [tns_pkg::TEXEL_W-1:0] rdata;

  tns_ram #(
    .WIDTH (tns_pkg::TEXEL_W),
    .DEPTH (tns_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (req.valid && !req.magenta),
    .we    (req.write),
    .addr  (req.addr),
    .wdata (req.data),
    .rdata (rdata)
  );

  // read-data stage flags
  logic rd_valid;
  logic rd_magenta;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= req.valid && !req.write;
    end
    rd_magenta <= req.magenta;
  end

  // result queue
  logic [tns_pkg::TEXEL_W-1:0] head;

  tns_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (rd_valid),
    .push_data (rd_magenta ? tns_pkg::MAGENTA : rdata),
    .pop       (out_fire),
    .not_empty (out_valid),
    .head      (head)
  );

  assign red   = head[7:0];
  assign green = head[15:8];
  assign blue  = head[23:16];
  assign alpha = head[31:24];

  `TNS_ASSERT_NOW(a_pend_bound, 1'b1, pending <= PEND_W'(tns_pkg::QDEPTH))
  `TNS_ASSERT_NOW(a_out_has_credit, out_valid, pending != '0)
  `TNS_ASSERT_NEXT(a_sample_counted, in_fire && is_sample && !out_fire, pending != '0)
  `TNS_ASSERT_NOW(a_no_read_on_write, rd_valid, !$past(req.write))

endmodule
`default_nettype wire

// ===== test/texture_nearest_sampler_core_tb.sv =====
// Self-checking testbench for the nearest-neighbor texture sampler core.
module texture_nearest_sampler_core_tb;
  import tns_pkg::*;

  localparam int MAX_SIDE  = 256;
  localparam int FRAC_BITS = 16;
  localparam longint unsigned FRAC_ONE  = 64'd1 << FRAC_BITS;
  localparam longint unsigned FRAC_MASK = FRAC_ONE - 1;

  localparam int RESET_CYCLES    = 6;
  // A load leaves nothing to wait on at the output, so give the store port
  // some slack before touching the side registers.
  localparam int SETTLE_CYCLES   = 12;
  // Cycles with no transfer on either channel before the run is abandoned.
  localparam int STALL_LIMIT     = 2000;
  localparam int N_DIRECTED      = 25;
  localparam int N_PHASES        = 12;
  // Samples on blank texels pull in an extra load, so the total input count
  // runs well above N_PHASES * ITEMS_PER_PHASE.
  localparam int ITEMS_PER_PHASE = 125;

  typedef enum logic [0:0] {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_op_t;

  // One line of the directed table. A config row uses reg_sel/reg_val only;
  // an item row with lit set carries its expected texel, otherwise the
  // shadow model supplies it.
  typedef struct packed {
    row_op_t              op;
    cfg_reg_t             reg_sel;
    logic [REG_W-1:0]     reg_val;
    kind_t                kind;
    logic [ADDR_W-1:0]    addr;
    logic [TEXEL_W-1:0]   rgba;
    logic [COORD_W-1:0]   u;
    logic [COORD_W-1:0]   v;
    logic                 lit;
    logic [TEXEL_W-1:0]   want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 kind;
  logic [ADDR_W-1:0]    texel_addr;
  logic [TEXEL_W-1:0]   texel_rgba;
  logic [COORD_W-1:0]   u_coord;
  logic [COORD_W-1:0]   v_coord;
  logic                 out_valid;
  logic                 out_ready;
  logic [CHAN_W-1:0]    red;
  logic [CHAN_W-1:0]    green;
  logic [CHAN_W-1:0]    blue;
  logic [CHAN_W-1:0]    alpha;

  // Shadow copy of the texel store and of the side registers.
  logic [TEXEL_W-1:0]   shadow_texels [STORE_DEPTH];
  bit                   shadow_written [STORE_DEPTH];
  logic [REG_W-1:0]     width_shadow;
  logic [REG_W-1:0]     height_shadow;

  // Texels still owed by the block, oldest first.
  logic [TEXEL_W-1:0]   expected_texels [$];

  int                   mismatches;
  int                   quiet_cycles;
  int                   sender_idle_pct;
  int                   receiver_stall_pct;

  // Directed table: reset state, both zero-side cases, 1x1 and 256x256
  // corners, u/v fraction extremes, saturation of oversized sides.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'h0000, 32'h0,
      32'h7FFF_FFFF, 32'h8000_0000, 1'b1, MAGENTA},
    '{ROW_CFG, REG_TEX_WIDTH, 9'd1, KIND_LOAD, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'h0000, 32'h0,
      32'h0000_0000, 32'h0000_0000, 1'b1, MAGENTA},
    '{ROW_CFG, REG_TEX_HEIGHT, 9'd1, KIND_LOAD, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_LOAD, 16'h0000, 32'hFFFF_FFFF,
      32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_LOAD, 16'hFFFF, 32'h0000_0000,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'h0000, 32'h0,
      32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_LOAD, 16'h0000, 32'h1234_5678,
      32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h1234_5678},
    '{ROW_CFG, REG_TEX_WIDTH, 9'd256, KIND_LOAD, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_CFG, REG_TEX_HEIGHT, 9'd256, KIND_LOAD, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_LOAD, 16'hFFFE, 32'hA5C3_3C5A,
      32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'h0000, 32'h0,
      32'h0000_FFFF, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'h0000, 32'h0,
      32'h0000_0000, 32'h0000_FFFF, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'h0000, 32'h0,
      32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'h0000, 32'h0,
      32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_CFG, REG_TEX_WIDTH, 9'd511, KIND_LOAD, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_CFG, REG_TEX_HEIGHT, 9'd300, KIND_LOAD, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'h0000, 32'h0,
      32'h0000_8000, 32'h0000_8000, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'h0000, 32'h0,
      32'h7FFF_FFFF, 32'h8000_0001, 1'b0, 32'h0},
    '{ROW_CFG, REG_TEX_WIDTH, 9'd0, KIND_LOAD, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'h0000, 32'h0,
      32'h1234_5678, 32'h9ABC_DEF0, 1'b1, MAGENTA},
    '{ROW_CFG, REG_TEX_WIDTH, 9'd3, KIND_LOAD, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_CFG, REG_TEX_HEIGHT, 9'd2, KIND_LOAD, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_TEX_WIDTH, 9'd0, KIND_SAMPLE, 16'h0000, 32'h0,
      32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0}
  };

  texture_nearest_sampler_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .texel_addr (texel_addr),
    .texel_rgba (texel_rgba),
    .u_coord    (u_coord),
    .v_coord    (v_coord),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  // Row-major store index hit by a sample at (u, v) under the current sides.
  // u keeps its low fraction bits (floor wrap); v is flipped to one minus its
  // fraction, so a zero fraction lands on the last row. Sides saturate at
  // MAX_SIDE; the product with side-1 is truncated, then clamped.
  function automatic logic [ADDR_W-1:0] texel_index(logic [COORD_W-1:0] u,
                                                    logic [COORD_W-1:0] v);
    longint unsigned w;
    longint unsigned h;
    longint unsigned uf;
    longint unsigned vf;
    longint unsigned x;
    longint unsigned y;
    longint unsigned flat;
    w  = (width_shadow > MAX_SIDE) ? MAX_SIDE : width_shadow;
    h  = (height_shadow > MAX_SIDE) ? MAX_SIDE : height_shadow;
    uf = u & FRAC_MASK;
    vf = FRAC_ONE - (v & FRAC_MASK);
    x  = (uf * (w - 1)) >> FRAC_BITS;
    y  = (vf * (h - 1)) >> FRAC_BITS;
    if (x > w - 1) x = w - 1;
    if (y > h - 1) y = h - 1;
    flat = y * w + x;
    return flat[ADDR_W-1:0];
  endfunction

  function automatic bit texture_present();
    return (width_shadow != 0) && (height_shadow != 0);
  endfunction

  // Texel a sample returns; magenta whenever either side is zero.
  function automatic logic [TEXEL_W-1:0] predict_texel(logic [COORD_W-1:0] u,
                                                       logic [COORD_W-1:0] v);
    if (!texture_present()) return MAGENTA;
    return shadow_texels[texel_index(u, v)];
  endfunction

  // Random coordinate; now and then the fraction is forced to zero or all
  // ones, the two ends of the wrap and of the v flip.
  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] c;
    c = $urandom;
    case ($urandom_range(7))
      0: c[FRAC_BITS-1:0] = '0;
      1: c[FRAC_BITS-1:0] = '1;
      default: ;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Side registers are only written with the pipe empty.
  task automatic write_reg(cfg_reg_t sel, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    if (sel == REG_TEX_WIDTH) width_shadow = val;
    else height_shadow = val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One input transfer. Inputs move on the falling edge; in_ready is looked
  // at on the rising edge. Valid is never dropped between back-to-back
  // transfers, only during a sender gap.
  task automatic drive_transfer(kind_t k, logic [ADDR_W-1:0] a, logic [TEXEL_W-1:0] d,
                                logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                                bit lit, logic [TEXEL_W-1:0] want);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    texel_addr <= a;
    texel_rgba <= d;
    u_coord    <= u;
    v_coord    <= v;
    do @(posedge clk); while (!in_ready);
    if (k == KIND_LOAD) begin
      shadow_texels[a]  = d;
      shadow_written[a] = 1'b1;
    end else begin
      expected_texels.push_back(lit ? want : predict_texel(u, v));
    end
  endtask

  // A sample never reads a texel that was never loaded: if the target is
  // still blank, a load with random content goes in first.
  task automatic issue_item(kind_t k, logic [ADDR_W-1:0] a, logic [TEXEL_W-1:0] d,
                            logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                            bit lit, logic [TEXEL_W-1:0] want);
    logic [ADDR_W-1:0] target;
    if (k == KIND_SAMPLE && !lit && texture_present()) begin
      target = texel_index(u, v);
      if (!shadow_written[target])
        drive_transfer(KIND_LOAD, target, $urandom, $urandom, $urandom, 1'b0, '0);
    end
    drive_transfer(k, a, d, u, v, lit, want);
  endtask

  // Let every owed texel come out, then give in-flight loads time to land.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_texels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Side settings per random phase: unit, full, oversized, thin strips,
  // no texture on either axis, and random sizes.
  task automatic setup_phase(int p);
    logic [REG_W-1:0] w;
    logic [REG_W-1:0] h;
    case (p)
      0:  begin w = 9'd1;   h = 9'd1;   end
      1:  begin w = 9'd256; h = 9'd256; end
      2:  begin w = 9'd511; h = 9'd511; end
      3:  begin w = 9'd2;   h = 9'd256; end
      4:  begin w = 9'd256; h = 9'd1;   end
      5:  begin w = 9'd0;   h = 9'($urandom_range(1, 256)); end
      6:  begin w = 9'($urandom_range(3, 16));    h = 9'($urandom_range(3, 16)); end
      7:  begin w = 9'($urandom_range(257, 511)); h = 9'($urandom_range(1, 8));  end
      8:  begin w = 9'($urandom_range(1, 32));    h = 9'($urandom_range(1, 32)); end
      9:  begin w = 9'($urandom_range(1, 256));   h = 9'($urandom_range(1, 256)); end
      10: begin w = 9'($urandom_range(1, 256));   h = 9'd0; end
      default: begin w = 9'd255; h = 9'd255; end
    endcase
    write_reg(REG_TEX_WIDTH, w);
    write_reg(REG_TEX_HEIGHT, h);
    // Rotate through: no gaps, sender gaps, receiver stalls, light both.
    case (p % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
      default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
    endcase
  endtask

  // Receiver: back-pressure on the result channel.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result check
  // ---------------------------------------------------------------------------

  task automatic check_chan(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    logic [TEXEL_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_texels.size() == 0) begin
        $error("result transfer with nothing outstanding: %h %h %h %h",
               red, green, blue, alpha);
        mismatches++;
      end else begin
        want = expected_texels.pop_front();
        check_chan("red",   want[7:0],   red);
        check_chan("green", want[15:8],  green);
        check_chan("blue",  want[23:16], blue);
        check_chan("alpha", want[31:24], alpha);
      end
    end
  end

  // Watchdog: counts cycles without a transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("texture_nearest_sampler_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int  pick;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_TEX_WIDTH;
    cfg_data           = '0;
    in_valid           = 1'b0;
    kind               = KIND_LOAD;
    texel_addr         = '0;
    texel_rgba         = '0;
    u_coord            = '0;
    v_coord            = '0;
    out_ready          = 1'b1;
    width_shadow       = '0;
    height_shadow      = '0;
    mismatches         = 0;
    quiet_cycles       = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table; config rows wait for the pipe to empty first.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].op == ROW_CFG) begin
        drain();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      end else begin
        issue_item(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].rgba,
                   directed_rows[i].u, directed_rows[i].v,
                   directed_rows[i].lit, directed_rows[i].want);
      end
    end

    // Random phases. Mostly samples (each preceded by a load when its texel
    // is blank), plus loads that overwrite texels inside the texture and
    // stray loads anywhere in the store.
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      setup_phase(p);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 8 && texture_present()) begin
          issue_item(KIND_LOAD,
                     ADDR_W'($urandom_range(0, width_shadow * height_shadow - 1)),
                     $urandom, $urandom, $urandom, 1'b0, '0);
        end else if (pick < 15) begin
          issue_item(KIND_LOAD, ADDR_W'($urandom), $urandom, $urandom, $urandom, 1'b0, '0);
        end else begin
          issue_item(KIND_SAMPLE, ADDR_W'($urandom), $urandom, rand_coord(), rand_coord(),
                     1'b0, '0);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("texture_nearest_sampler_core: match");
    end else begin
      $display("texture_nearest_sampler_core: mismatch");
    end
    $finish;
  end

endmodule
